FILE: src/slot_alloc_pkg.sv
// Shared types and constants of the indexed slot allocator.
package slot_alloc_pkg;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_LIST  = 2'd3
  } op_e;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic REG_SLOTS_IN_USE = 1'b0;
  localparam logic REG_SLOT_BYTES   = 1'b1;

  // Largest slot size used when forming a byte offset.
  localparam logic [12:0] MAX_SLOT_BYTES = 13'd4096;

  // Reset value of the slot size register.
  localparam logic [12:0] SLOT_BYTES_RESET = 13'd16;

  typedef struct packed {
    op_e        operation;
    logic [5:0] slot;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot_index;
    logic [17:0] byte_offset;
    logic [6:0]  busy_count;
    logic        last;
  } res_t;

endpackage

FILE: src/indexed_slot_allocator_unit.sv
// Slot allocator with index-linked free and busy lists, sequenced over link memories.
//
// Init, allocate when full, free when empty or of a slot that is not busy, and list of
// an empty pool finish in the accept cycle: the result is registered for the next cycle, busy stays low.
// Allocate steps through S_ALLOC_LINK and S_ALLOC_FIX, free through S_FREE_UNLINK and
// S_FREE_PUSH, with busy high, so no new request is accepted before the result; the single
// read and write port of each link memory sets these steps. List gives one result per
// cycle for k busy slots, paced by the registered next-link read. Results cannot be stalled by the receiver.
// Synchronous reset rebuilds the pool over all slots; no clearing pass is run.
module indexed_slot_allocator_unit
  import slot_alloc_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  req_t        in_req,
  // result channel
  output logic        out_valid,
  output res_t        out_res,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // IW addresses a slot, LW holds a link, which may also be the "no slot" marker.
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NONE = LW'(CAPACITY);
  localparam logic [6:0] CAP7 = 7'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_LINK,
    S_ALLOC_FIX,
    S_FREE_UNLINK,
    S_FREE_PUSH,
    S_LIST_WALK
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. The register index is paddr[2]; the low address
  // bits are not decoded.
  // ---------------------------------------------------------------------------
  logic [6:0]  slots_in_use_r;
  logic [12:0] slot_bytes_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= CAP7;
      slot_bytes_r   <= SLOT_BYTES_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SLOTS_IN_USE) begin
        slots_in_use_r <= pwdata[6:0];
      end else begin
        slot_bytes_r <= pwdata[12:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SLOT_BYTES) begin
      prdata = {19'd0, slot_bytes_r};
    end else begin
      prdata = {25'd0, slots_in_use_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Link memories. Each has one write port and one registered read port.
  // Entries at or above the fill count have not been written since the last
  // init; their next link is implied by their position in the fresh run, so
  // init and reset need no sweep. Previous links are only ever read for busy
  // slots, and a slot always gets its previous link written when allocated.
  // ---------------------------------------------------------------------------
  logic [LW-1:0] next_mem [CAPACITY];
  logic [LW-1:0] prev_mem [CAPACITY];
  logic [LW-1:0] rd_next_r;
  logic [LW-1:0] rd_prev_r;

  logic          nw_en;
  logic [IW-1:0] nw_addr;
  logic [LW-1:0] nw_data;
  logic          pw_en;
  logic [IW-1:0] pw_addr;
  logic [LW-1:0] pw_data;
  logic [IW-1:0] nr_addr;
  logic [IW-1:0] pr_addr;

  always_ff @(posedge clk) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    rd_next_r <= next_mem[nr_addr];
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    rd_prev_r <= prev_mem[pr_addr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and list heads.
  // ---------------------------------------------------------------------------
  state_t        state_r, state_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] busy_head_r, busy_head_nxt;
  logic [LW-1:0] busy_total_r, busy_total_nxt;
  logic [LW-1:0] pool_limit_r, pool_limit_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic [CAPACITY-1:0] busy_mask_r, busy_mask_nxt;
  logic [LW-1:0] op_idx_r, op_idx_nxt;
  logic          fresh_r, fresh_nxt;
  logic [LW-1:0] list_cnt_r, list_cnt_nxt;
  logic          out_valid_r;
  res_t          out_res_r;

  logic          accept;
  logic          emit_en;
  status_e       emit_status;
  logic [5:0]    emit_slot;
  logic [LW-1:0] emit_count;
  logic          emit_last;
  logic [LW-1:0] pool_clamped;
  logic [LW-1:0] fresh_succ;
  logic [LW-1:0] unlink_p;
  logic [LW-1:0] unlink_n;
  logic          slot_busy;
  logic [12:0]   bytes_sat;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Init saturates the configured slot count to the pool's capacity and raises a zero count to one.
  always_comb begin
    if (slots_in_use_r == 7'd0) begin
      pool_clamped = LW'(1);
    end else if (slots_in_use_r > CAP7) begin
      pool_clamped = NONE;
    end else begin
      pool_clamped = LW'(slots_in_use_r);
    end
  end

  // Successor of a slot in the untouched run that init laid out.
  assign fresh_succ = (LW'(op_idx_r + LW'(1)) < pool_limit_r) ? LW'(op_idx_r + LW'(1)) : NONE;

  assign unlink_p  = rd_prev_r;
  assign unlink_n  = rd_next_r;
  assign slot_busy = ({1'b0, in_req.slot} < CAP7) && busy_mask_r[in_req.slot[IW-1:0]];
  assign bytes_sat = (slot_bytes_r > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : slot_bytes_r;

  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    busy_head_nxt  = busy_head_r;
    busy_total_nxt = busy_total_r;
    pool_limit_nxt = pool_limit_r;
    fill_nxt       = fill_r;
    busy_mask_nxt  = busy_mask_r;
    op_idx_nxt     = op_idx_r;
    fresh_nxt      = fresh_r;
    list_cnt_nxt   = list_cnt_r;

    emit_en     = 1'b0;
    emit_status = ST_OK;
    emit_slot   = 6'd0;
    emit_count  = busy_total_r;
    emit_last   = 1'b1;

    nw_en   = 1'b0;
    nw_addr = op_idx_r[IW-1:0];
    nw_data = busy_head_r;
    pw_en   = 1'b0;
    pw_addr = op_idx_r[IW-1:0];
    pw_data = NONE;
    nr_addr = op_idx_r[IW-1:0];
    pr_addr = op_idx_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req.operation)
            OP_INIT: begin
              pool_limit_nxt = pool_clamped;
              free_head_nxt  = '0;
              busy_head_nxt  = NONE;
              busy_total_nxt = '0;
              busy_mask_nxt  = '0;
              fill_nxt       = '0;
              emit_en        = 1'b1;
              emit_count     = '0;
            end
            OP_ALLOC: begin
              if (busy_total_r >= pool_limit_r || free_head_r >= NONE) begin
                emit_en     = 1'b1;
                emit_status = ST_FULL;
              end else begin
                op_idx_nxt = free_head_r;
                fresh_nxt  = (free_head_r >= fill_r);
                nr_addr    = free_head_r[IW-1:0];
                state_nxt  = S_ALLOC_LINK;
              end
            end
            OP_FREE: begin
              if (busy_total_r == '0) begin
                emit_en     = 1'b1;
                emit_status = ST_EMPTY;
              end else if (!slot_busy) begin
                // A slot that is not busy is echoed and otherwise ignored.
                emit_en   = 1'b1;
                emit_slot = in_req.slot;
              end else begin
                op_idx_nxt = LW'(in_req.slot);
                nr_addr    = in_req.slot[IW-1:0];
                pr_addr    = in_req.slot[IW-1:0];
                state_nxt  = S_FREE_UNLINK;
              end
            end
            OP_LIST: begin
              if (busy_total_r == '0) begin
                emit_en     = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                emit_en      = 1'b1;
                emit_slot    = 6'(busy_head_r);
                emit_last    = (busy_total_r == LW'(1));
                nr_addr      = busy_head_r[IW-1:0];
                list_cnt_nxt = LW'(1);
                if (busy_total_r != LW'(1)) begin
                  state_nxt = S_LIST_WALK;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_ALLOC_LINK: begin
        // Pop the free head and make it the new busy head.
        free_head_nxt = fresh_r ? fresh_succ : rd_next_r;
        if (fresh_r) begin
          fill_nxt = LW'(fill_r + LW'(1));
        end
        nw_en     = 1'b1;
        nw_data   = busy_head_r;
        pw_en     = 1'b1;
        pw_data   = NONE;
        state_nxt = S_ALLOC_FIX;
      end

      S_ALLOC_FIX: begin
        if (busy_head_r < NONE) begin
          pw_en   = 1'b1;
          pw_addr = busy_head_r[IW-1:0];
          pw_data = op_idx_r;
        end
        busy_head_nxt                    = op_idx_r;
        busy_mask_nxt[op_idx_r[IW-1:0]]  = 1'b1;
        busy_total_nxt                   = LW'(busy_total_r + LW'(1));
        emit_en                          = 1'b1;
        emit_slot                        = 6'(op_idx_r);
        emit_count                       = LW'(busy_total_r + LW'(1));
        state_nxt                        = S_IDLE;
      end

      S_FREE_UNLINK: begin
        // Bridge the neighbors; removing the head promotes its successor.
        if (unlink_p < NONE) begin
          nw_en   = 1'b1;
          nw_addr = unlink_p[IW-1:0];
          nw_data = unlink_n;
        end else begin
          busy_head_nxt = unlink_n;
        end
        if (unlink_n < NONE) begin
          pw_en   = 1'b1;
          pw_addr = unlink_n[IW-1:0];
          pw_data = unlink_p;
        end
        state_nxt = S_FREE_PUSH;
      end

      S_FREE_PUSH: begin
        nw_en                           = 1'b1;
        nw_data                         = free_head_r;
        free_head_nxt                   = op_idx_r;
        busy_mask_nxt[op_idx_r[IW-1:0]] = 1'b0;
        busy_total_nxt                  = LW'(busy_total_r - LW'(1));
        emit_en                         = 1'b1;
        emit_slot                       = 6'(op_idx_r);
        emit_count                      = LW'(busy_total_r - LW'(1));
        state_nxt                       = S_IDLE;
      end

      S_LIST_WALK: begin
        // The registered read data is the next busy slot; it also addresses
        // the following read, giving one result per cycle.
        emit_en      = 1'b1;
        emit_slot    = 6'(rd_next_r);
        emit_last    = (LW'(list_cnt_r + LW'(1)) == busy_total_r);
        nr_addr      = rd_next_r[IW-1:0];
        list_cnt_nxt = LW'(list_cnt_r + LW'(1));
        if (emit_last) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= '0;
      busy_head_r  <= NONE;
      busy_total_r <= '0;
      pool_limit_r <= NONE;
      fill_r       <= '0;
      busy_mask_r  <= '0;
      list_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      busy_head_r  <= busy_head_nxt;
      busy_total_r <= busy_total_nxt;
      pool_limit_r <= pool_limit_nxt;
      fill_r       <= fill_nxt;
      busy_mask_r  <= busy_mask_nxt;
      list_cnt_r   <= list_cnt_nxt;
      out_valid_r  <= emit_en;
    end
    op_idx_r <= op_idx_nxt;
    fresh_r  <= fresh_nxt;
    if (emit_en) begin
      out_res_r.status      <= emit_status;
      out_res_r.slot_index  <= emit_slot;
      out_res_r.byte_offset <= 18'({12'd0, emit_slot} * {5'd0, bytes_sat});
      out_res_r.busy_count  <= 7'(emit_count);
      out_res_r.last        <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  // The busy bits and the busy count describe the same set of slots.
  a_mask_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy_mask_r) == busy_total_r)
    else $error("busy mask and busy count disagree");

  // Never more busy slots, nor more fresh slots consumed, than the pool holds.
  a_pool_bound : assert property (@(posedge clk) disable iff (!rst_n)
    busy_total_r <= pool_limit_r && fill_r <= pool_limit_r)
    else $error("pool bookkeeping exceeds the pool size");

  // A list walk stops before it has emitted more slots than are busy.
  a_walk_bound : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LIST_WALK |-> list_cnt_r < busy_total_r)
    else $error("list walk ran past the busy count");

  // A result only follows an accepted request or a sequencer step.
  a_result_cause : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy || start))
    else $error("result without a request");

  // The last result of a request returns the block to idle.
  a_last_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.last |-> state_r == S_IDLE)
    else $error("final result while the sequencer is still working");
`endif

endmodule
